>>> hw/rtl/m2m_pkg.sv
// Shared types and constants for the MUS to MIDI event converter.
package m2m_pkg;

  localparam logic [27:0] DELAY_MAX = 28'hFFFFFFF;

  typedef struct packed {
    logic [7:0] score_byte;
    logic       start_of_score;
  } m2m_in_t;

  typedef struct packed {
    logic [7:0]  midi_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        score_done;
    logic [1:0]  status;
    logic [31:0] track_length;
  } m2m_out_t;

  typedef enum logic [2:0] {
    PH_DESC    = 3'd0,
    PH_OPERAND = 3'd1,
    PH_SECOND  = 3'd2,
    PH_DELAY   = 3'd3,
    PH_DONE    = 3'd4,
    PH_HALT    = 3'd5
  } m2m_phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_EV  = 2'd1,
    ST_BAD_CTL = 2'd2
  } m2m_status_t;

  // Command kinds handed from the parser to the byte emitter.
  typedef enum logic [1:0] {
    CMD_EVENT3 = 2'd0,  // delta + status + a + b
    CMD_EVENT2 = 2'd1,  // delta + status + a
    CMD_FAIL   = 2'd2,  // status-only result
    CMD_END    = 2'd3   // delta + FF 2F 00, with length
  } m2m_cmd_kind_t;

  typedef struct packed {
    m2m_cmd_kind_t kind;
    logic          clear;    // reset byte count before this command
    logic          last;     // final command caused by this input byte
    logic [27:0]   delta;
    logic [7:0]    st;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [1:0]    code;
  } m2m_cmd_t;

  // Standard MUS controller number to MIDI controller number.
  function automatic logic [6:0] ctl_map(input logic [3:0] n);
    logic [6:0] v;
    case (n)
      4'd0:  v = 7'h00;
      4'd1:  v = 7'h20;
      4'd2:  v = 7'h01;
      4'd3:  v = 7'h07;
      4'd4:  v = 7'h0A;
      4'd5:  v = 7'h0B;
      4'd6:  v = 7'h5B;
      4'd7:  v = 7'h5D;
      4'd8:  v = 7'h40;
      4'd9:  v = 7'h43;
      4'd10: v = 7'h78;
      4'd11: v = 7'h7B;
      4'd12: v = 7'h7E;
      4'd13: v = 7'h7F;
      4'd14: v = 7'h79;
      default: v = 7'h00;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/m2m_parser.sv
// Front end: parses MUS bytes, maps channels and issues emit commands.
module m2m_parser import m2m_pkg::*; #(
  parameter int CHANNEL_COUNT     = 16,
  parameter int MIDI_DRUM_CHANNEL = 9,
  parameter int MUS_DRUM_CHANNEL  = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  m2m_in_t  in_data,
  output logic     cmd_push,
  input  logic     cmd_room2,   // queue has space for two commands
  output m2m_cmd_t cmd_a,
  output logic     cmd_b_push,
  output m2m_cmd_t cmd_b
);

  localparam logic [3:0] LAST_CH = 4'(CHANNEL_COUNT - 1);
  localparam logic [3:0] MDRUM   = 4'(MIDI_DRUM_CHANNEL);
  localparam logic [3:0] SDRUM   = 4'(MUS_DRUM_CHANNEL);

  m2m_phase_t  phase_r, phase_nxt;
  logic [7:0]  desc_r, desc_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] asg_v_r, asg_v_nxt;
  logic [3:0]  asg_c_r [16];
  logic        hi_v_r, hi_v_nxt;
  logic [3:0]  hi_c_r, hi_c_nxt;
  logic [6:0]  vel_r [16];
  logic [27:0] pend_r, pend_nxt;
  logic [27:0] acc_r, acc_nxt;
  logic        clr_pend_r;

  logic        take, clr, clr_any;
  m2m_phase_t  ph;
  logic [7:0]  desc, b, ctlv;
  logic [15:0] asg_v;
  logic        hi_v;
  logic [3:0]  chn, idx, ch, alloc_c, alloc_idx;
  logic [27:0] pend, acc;
  logic [4:0]  r;
  logic        do_alloc, vel_we;
  logic [3:0]  vel_idx;
  logic [35:0] acc_w;
  logic [28:0] psum;
  logic [13:0] pw;
  m2m_cmd_t    ev;
  logic        ev_v;

  assign in_full = !cmd_room2;
  assign take    = in_push && cmd_room2;
  assign b       = in_data.score_byte;
  assign clr     = in_data.start_of_score;
  // Carry a restart that produced no command to the next command issued
  assign clr_any = clr || clr_pend_r;

  always_comb begin
    ph    = clr ? PH_DESC : phase_r;
    desc  = clr ? 8'd0 : desc_r;
    asg_v = clr ? 16'd0 : asg_v_r;
    hi_v  = clr ? 1'b0 : hi_v_r;
    pend  = clr ? 28'd0 : pend_r;
    acc   = clr ? 28'd0 : acc_r;
  end

  // Channel of the current descriptor
  always_comb begin
    chn = desc[3:0];
    idx = (chn > LAST_CH) ? LAST_CH : chn;
    if (chn == SDRUM) ch = MDRUM;
    else              ch = asg_c_r[idx];
    if (!asg_v[idx] && chn != SDRUM) ch = 4'd0;
  end

  always_comb begin
    phase_nxt = ph;
    desc_nxt  = desc;
    held_nxt  = clr ? 8'd0 : held_r;
    asg_v_nxt = asg_v;
    hi_v_nxt  = hi_v;
    hi_c_nxt  = hi_c_r;
    pend_nxt  = pend;
    acc_nxt   = acc;
    do_alloc  = 1'b0;
    alloc_idx = b[3:0] > LAST_CH ? LAST_CH : b[3:0];
    r         = hi_v ? {1'b0, hi_c_r} + 5'd1 : 5'd0;
    if (r == {1'b0, MDRUM}) r = r + 5'd1;
    alloc_c   = (r > 5'd15) ? 4'd15 : r[3:0];
    vel_we    = 1'b0;
    vel_idx   = ch;
    ctlv      = b[7] ? 8'h7F : b;
    pw        = {b, 6'd0};
    acc_w     = {acc, 8'd0} >> 1;
    acc_w     = acc_w + {29'd0, b[6:0]};
    psum      = {1'b0, pend} + {1'b0, acc_nxt};
    cmd_a     = '0;
    cmd_b     = '0;
    ev        = '0;
    ev_v      = 1'b0;
    cmd_a.clear = clr_any;
    ev.delta  = pend;

    unique case (ph)
      PH_DESC: begin
        desc_nxt = b;
        if (b[3:0] != SDRUM && !asg_v[alloc_idx]) do_alloc = 1'b1;
        if (b[6:4] <= 3'd4) phase_nxt = PH_OPERAND;
        else if (b[6:4] == 3'd6) begin
          ev_v = 1'b1; ev.kind = CMD_END;
          ev.st = 8'hFF; ev.a = 8'h2F; ev.b = 8'h00;
          phase_nxt = PH_DONE;
        end else begin
          ev_v = 1'b1; ev.kind = CMD_FAIL; ev.code = ST_BAD_EV;
          phase_nxt = PH_HALT;
        end
      end
      PH_OPERAND: begin
        held_nxt = b;
        phase_nxt = desc[7] ? PH_DELAY : PH_DESC;
        unique case (desc[6:4])
          3'd0: begin
            ev_v = 1'b1; ev.st = {4'h8, ch}; ev.a = {1'b0, b[6:0]};
          end
          3'd1: begin
            if (b[7]) phase_nxt = PH_SECOND;
            else begin
              ev_v = 1'b1; ev.st = {4'h9, ch}; ev.a = {1'b0, b[6:0]};
              ev.b = {1'b0, vel_r[ch]};
            end
          end
          3'd2: begin
            ev_v = 1'b1; ev.st = {4'hE, ch};
            ev.a = {1'b0, pw[6:0]}; ev.b = {1'b0, pw[13:7]};
          end
          3'd3: begin
            if (b >= 8'd10 && b <= 8'd14) begin
              ev_v = 1'b1; ev.st = {4'hB, ch}; ev.a = {1'b0, ctl_map(b[3:0])};
            end else begin
              ev_v = 1'b1; ev.kind = CMD_FAIL; ev.code = ST_BAD_CTL;
              phase_nxt = PH_HALT;
            end
          end
          3'd4: phase_nxt = PH_SECOND;
          default: phase_nxt = PH_HALT;
        endcase
      end
      PH_SECOND: begin
        phase_nxt = desc[7] ? PH_DELAY : PH_DESC;
        ev_v = 1'b1;
        if (desc[6:4] == 3'd1) begin
          vel_we = 1'b1;
          ev.st = {4'h9, ch}; ev.a = {1'b0, held_r[6:0]}; ev.b = {1'b0, b[6:0]};
        end else if (held_r == 8'd0) begin
          ev.kind = CMD_EVENT2; ev.st = {4'hC, ch}; ev.a = {1'b0, b[6:0]};
        end else if (held_r <= 8'd9) begin
          ev.st = {4'hB, ch}; ev.a = {1'b0, ctl_map(held_r[3:0])}; ev.b = ctlv;
        end else begin
          ev.kind = CMD_FAIL; ev.code = ST_BAD_CTL;
          phase_nxt = PH_HALT;
        end
      end
      PH_DELAY: begin
        acc_nxt = (acc_w > {8'd0, DELAY_MAX}) ? DELAY_MAX : acc_w[27:0];
        if (!b[7]) begin
          psum     = {1'b0, pend} + {1'b0, acc_nxt};
          pend_nxt = psum[28] ? DELAY_MAX : psum[27:0];
          acc_nxt  = 28'd0;
          phase_nxt = PH_DESC;
        end
      end
      default: ;
    endcase

    if (ev_v && ev.kind != CMD_FAIL) pend_nxt = 28'd0;
    if ((ph == PH_OPERAND || ph == PH_SECOND) && ev_v && ev.kind != CMD_FAIL && desc[7])
      acc_nxt = 28'd0;

    if (do_alloc) begin
      asg_v_nxt[alloc_idx] = 1'b1;
      hi_v_nxt = 1'b1;
      hi_c_nxt = alloc_c;
      cmd_a.kind = CMD_EVENT3; cmd_a.delta = pend;
      cmd_a.st = {4'hB, alloc_c}; cmd_a.a = 8'h7B; cmd_a.b = 8'h00;
      cmd_a.last = !ev_v;
      ev.delta = 28'd0;
      ev.last = 1'b1;
      if (!ev_v) pend_nxt = 28'd0;
      cmd_b = ev;
    end else begin
      ev.clear = clr_any;
      ev.last = 1'b1;
      cmd_a = ev;
    end
  end

  assign cmd_push   = take && (do_alloc || ev_v);
  assign cmd_b_push = take && do_alloc && ev_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DESC;
      desc_r     <= 8'd0;
      held_r     <= 8'd0;
      asg_v_r    <= 16'd0;
      hi_v_r     <= 1'b0;
      pend_r     <= 28'd0;
      acc_r      <= 28'd0;
      clr_pend_r <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      desc_r     <= desc_nxt;
      held_r     <= held_nxt;
      asg_v_r    <= asg_v_nxt;
      hi_v_r     <= hi_v_nxt;
      pend_r     <= pend_nxt;
      acc_r      <= acc_nxt;
      clr_pend_r <= clr_any && !(do_alloc || ev_v);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hi_c_r <= hi_c_nxt;
      if (do_alloc) asg_c_r[alloc_idx] <= alloc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) vel_r[i] <= 7'h7F;
    end else if (take && vel_we) begin
      vel_r[vel_idx] <= b[6:0];
    end
  end

endmodule

>>> hw/rtl/m2m_cmd_fifo.sv
// Command queue between parser and emitter; takes up to two entries per cycle.
module m2m_cmd_fifo import m2m_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_a,
  input  m2m_cmd_t din_a,
  input  logic     wr_b,
  input  m2m_cmd_t din_b,
  output logic     room2,
  output logic     rd_valid,
  input  logic     rd_take,
  output m2m_cmd_t dout
);

  m2m_cmd_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;

  assign room2    = cnt_r <= 3'd2;
  assign rd_valid = cnt_r != 3'd0;
  assign dout     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 3'(wr_a) + 3'(wr_b) - 3'(rd_take && rd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + 2'(wr_a) + 2'(wr_b);
      rp_r  <= rp_r + 2'(rd_take && rd_valid);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) mem_r[wp_r] <= din_a;
    if (wr_b) mem_r[wp_r + 2'd1] <= din_b;
  end

endmodule

>>> hw/rtl/m2m_emitter.sv
// Back end: serializes commands into MIDI track bytes with delta times.
module m2m_emitter import m2m_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  m2m_cmd_t cmd,
  output logic     cmd_take,
  output logic     out_empty,
  input  logic     out_pop,
  output m2m_out_t out_data
);

  logic [2:0]  step_r, step_nxt;
  logic [31:0] cnt_r, cnt_nxt, base;
  logic        ov_r;
  m2m_out_t    ob_r, ob;
  logic [1:0]  grp;
  logic [2:0]  nsteps;
  logic [1:0]  g;
  logic [6:0]  v;
  logic        adv, is_last;

  assign out_empty = !ov_r;
  assign out_data  = ob_r;
  assign adv       = cmd_valid && (!ov_r || out_pop);
  assign base      = cmd.clear ? 32'd0 : cnt_r;

  always_comb begin
    if (cmd.delta[27:21] != 7'd0)      grp = 2'd3;
    else if (cmd.delta[20:14] != 7'd0) grp = 2'd2;
    else if (cmd.delta[13:7] != 7'd0)  grp = 2'd1;
    else                               grp = 2'd0;
    case (cmd.kind)
      CMD_EVENT2: nsteps = 3'(grp) + 3'd3;
      CMD_FAIL:   nsteps = 3'd1;
      default:    nsteps = 3'(grp) + 3'd4;
    endcase
    is_last = (step_r + 3'd1) == nsteps;
    g = 2'(grp - 2'(step_r));
    case (g)
      2'd3:    v = cmd.delta[27:21];
      2'd2:    v = cmd.delta[20:14];
      2'd1:    v = cmd.delta[13:7];
      default: v = cmd.delta[6:0];
    endcase
    ob = '0;
    ob.byte_valid = 1'b1;
    if (cmd.kind == CMD_FAIL) begin
      ob.byte_valid = 1'b0;
      ob.status = cmd.code;
    end else if (step_r <= 3'(grp)) begin
      ob.midi_byte = {(g != 2'd0), v};
    end else if (step_r == 3'(grp) + 3'd1) ob.midi_byte = cmd.st;
    else if (step_r == 3'(grp) + 3'd2)     ob.midi_byte = cmd.a;
    else                                   ob.midi_byte = cmd.b;
    ob.last_of_run = is_last && cmd.last;
    cnt_nxt = (step_r == 3'd0 ? base : cnt_r) + 32'(ob.byte_valid);
    if (cmd.kind == CMD_END && is_last) begin
      ob.score_done   = 1'b1;
      ob.track_length = cnt_nxt;
    end
    step_nxt = is_last ? 3'd0 : step_r + 3'd1;
  end

  assign cmd_take = adv && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      cnt_r  <= 32'd0;
      ov_r   <= 1'b0;
    end else begin
      if (adv) begin
        step_r <= step_nxt;
        cnt_r  <= cnt_nxt;
        ov_r   <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) ob_r <= ob;
  end

endmodule

>>> hw/rtl/mus_to_midi_event_converter_core.sv
// Top level of the MUS score to MIDI track body converter.
// Push one MUS score byte per transfer; MIDI track bytes come out in order on a
// queue-style result port. The parser takes a byte per cycle while the command
// queue has room for two entries; the emitter sends one result per cycle while
// results are popped in time. An event gives 1 to 7 results by its byte count
// (delta, status and data bytes), a new channel's all-notes-off 4 to 7 more.
// Halted or finished scores give no results until start_of_score.
module mus_to_midi_event_converter_core import m2m_pkg::*; #(
  parameter int CHANNEL_COUNT     = 16,
  parameter int MIDI_DRUM_CHANNEL = 9,
  parameter int MUS_DRUM_CHANNEL  = 15
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  m2m_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output m2m_out_t out_data
);

  m2m_cmd_t cmd_a, cmd_b, q_dout;
  logic     wr_a, wr_b, room2, q_valid, q_take;

  // Front: classify score bytes into commands
  m2m_parser #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .MIDI_DRUM_CHANNEL(MIDI_DRUM_CHANNEL),
    .MUS_DRUM_CHANNEL(MUS_DRUM_CHANNEL)
  ) u_parser (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_push(wr_a), .cmd_room2(room2), .cmd_a,
    .cmd_b_push(wr_b), .cmd_b
  );

  // Queue: decouple parsing from serialization
  m2m_cmd_fifo u_fifo (
    .clk, .rst_n, .wr_a, .din_a(cmd_a), .wr_b, .din_b(cmd_b),
    .room2, .rd_valid(q_valid), .rd_take(q_take), .dout(q_dout)
  );

  // Back: transfer bytes out
  m2m_emitter u_emit (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd(q_dout), .cmd_take(q_take),
    .out_empty, .out_pop, .out_data
  );

endmodule
